// ----- rtl/core/golay_pkg.sv -----
// Types, code tables and helper functions for the extended Golay (24,12) codec.
package golay_pkg;

  localparam int unsigned DataW = 12;
  localparam int unsigned WordW = 24;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef struct packed {
    op_e              opcode;
    logic [WordW-1:0] word_in;
  } golay_req_t;

  typedef struct packed {
    logic [WordW-1:0] result_word;
    logic [WordW-1:0] error_mask;
    logic             uncorrectable;
  } golay_rsp_t;

  localparam logic [DataW-1:0] ENC_ROWS [DataW] = '{
    12'hC75, 12'h49F, 12'hD4B, 12'h6E3, 12'h9B3, 12'hB66,
    12'hECC, 12'h1ED, 12'h3DA, 12'h7B4, 12'hB1D, 12'hE3A
  };

  localparam logic [DataW-1:0] INV_ROWS [DataW] = '{
    12'h49F, 12'h93E, 12'h6E3, 12'hDC6, 12'hF13, 12'hAB9,
    12'h1ED, 12'h3DA, 12'h7B4, 12'hF68, 12'hA4F, 12'hC75
  };

  function automatic logic [DataW-1:0] enc_mul(logic [DataW-1:0] v);
    logic [DataW-1:0] acc;
    acc = '0;
    for (int k = 0; k < DataW; k++) begin
      if (v[k]) begin
        acc = acc ^ ENC_ROWS[k];
      end
    end
    return acc;
  endfunction

  function automatic logic [DataW-1:0] inv_mul(logic [DataW-1:0] v);
    logic [DataW-1:0] acc;
    acc = '0;
    for (int k = 0; k < DataW; k++) begin
      if (v[k]) begin
        acc = acc ^ INV_ROWS[k];
      end
    end
    return acc;
  endfunction

  function automatic logic [3:0] ones12(logic [DataW-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < DataW; k++) begin
      n = n + {3'b000, v[k]};
    end
    return n;
  endfunction

endpackage

// ----- rtl/core/golay_24_12_codec.sv -----
// Extended Golay (24,12,8) encoder and up-to-three-error decoder, top level.
//
// Request channel: a request (opcode, word_in) is taken at a rising edge with
// start high and busy low. busy stays low, so a request may be issued every
// cycle. Encode appends 12 parity bits to the data in bits 11..0. Decode
// forms the syndrome, searches the four error patterns in priority order and
// returns the corrected data, the error mask and an uncorrectable flag.
//
// Result channel: done_o marks each result for a single cycle, with rsp_o
// valid in that cycle. A taken request is held in the request register and
// then passes through the syndrome, search and select logic into the result
// register, from which it is shown. One request can be taken per cycle; the
// syndrome and inverse-syndrome XOR trees with their weight checks set the
// cycle time. The receiver cannot stall; every result is shown once.
//
// Reset clears both valid flags; requests in flight are dropped and no result
// is shown until a new request is taken.
module golay_24_12_codec
  import golay_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  golay_req_t req_i,
  output logic       busy,
  output logic       done_o,
  output golay_rsp_t rsp_o
);

  logic             in_vld_q;
  golay_req_t       req_q;
  logic             out_vld_q;
  golay_rsp_t       rsp_q;
  golay_rsp_t       rsp_d;

  logic [DataW-1:0] data;
  logic [DataW-1:0] par;
  logic [DataW-1:0] syn;
  logic [DataW-1:0] isyn;
  logic             hit1;
  logic             hit2;
  logic             hit3;
  logic             hit4;
  logic [WordW-1:0] mask2;
  logic [WordW-1:0] mask4;
  logic [WordW-1:0] mask;
  logic             found;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start && !busy;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
    if (in_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign data = req_q.word_in[DataW-1:0];
  assign par  = req_q.word_in[WordW-1:DataW];
  assign syn  = par ^ enc_mul(data);
  assign isyn = inv_mul(syn);
  assign hit1 = ones12(syn) <= 4'd3;
  assign hit3 = ones12(isyn) <= 4'd3;

  always_comb begin
    logic [DataW-1:0] rest;
    hit2  = 1'b0;
    mask2 = '0;
    hit4  = 1'b0;
    mask4 = '0;
    for (int k = DataW - 1; k >= 0; k--) begin
      rest = syn ^ ENC_ROWS[k];
      if (ones12(rest) <= 4'd2) begin
        hit2  = 1'b1;
        mask2 = {rest, {DataW{1'b0}}} | (WordW'(1) << k);
      end
      rest = isyn ^ INV_ROWS[k];
      if (ones12(rest) <= 4'd2) begin
        hit4  = 1'b1;
        mask4 = {{DataW{1'b0}}, rest} | (WordW'(1) << (k + DataW));
      end
    end
  end

  always_comb begin
    found = 1'b1;
    priority if (hit1) begin
      mask = {syn, {DataW{1'b0}}};
    end else if (hit2) begin
      mask = mask2;
    end else if (hit3) begin
      mask = {{DataW{1'b0}}, isyn};
    end else if (hit4) begin
      mask = mask4;
    end else begin
      mask  = '0;
      found = 1'b0;
    end
  end

  always_comb begin
    rsp_d = '0;
    unique case (req_q.opcode)
      OP_ENCODE: begin
        rsp_d.result_word = {enc_mul(data), data};
      end
      OP_DECODE: begin
        if (found) begin
          rsp_d.result_word = {{DataW{1'b0}}, data ^ mask[DataW-1:0]};
          rsp_d.error_mask  = mask;
        end else begin
          rsp_d.uncorrectable = 1'b1;
        end
      end
      default: begin
        rsp_d = '0;
      end
    endcase
  end

  assign done_o = out_vld_q;
  assign rsp_o  = rsp_q;

  a_two_cycle_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("request did not produce a result two cycles later");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |=> !done_o)
    else $error("result shown without a request");

  a_uncorr_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.uncorrectable) |->
      (rsp_o.error_mask == '0 && rsp_o.result_word == '0))
    else $error("uncorrectable result carries data or mask");

  a_mask_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($countones(rsp_o.error_mask) <= 3))
    else $error("error mask heavier than three bits");

  a_decode_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && req_q.opcode == OP_DECODE) |=>
      (rsp_o.result_word[WordW-1:DataW] == '0))
    else $error("decode result has upper bits set");

endmodule

// ----- tb/golay_codec_checker.sv -----
// Checker for the Golay (24,12) codec: predicts each request's result and compares.
module golay_codec_checker
  import golay_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  golay_req_t req_i,
  input  logic       done_i,
  input  golay_rsp_t rsp_i,
  output int         pending_o,
  output int         fail_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [11:0] PARITY_ROWS [12] = '{
    12'hC75, 12'h49F, 12'hD4B, 12'h6E3, 12'h9B3, 12'hB66,
    12'hECC, 12'h1ED, 12'h3DA, 12'h7B4, 12'hB1D, 12'hE3A
  };

  localparam logic [11:0] INVERSE_ROWS [12] = '{
    12'h49F, 12'h93E, 12'h6E3, 12'hDC6, 12'hF13, 12'hAB9,
    12'h1ED, 12'h3DA, 12'h7B4, 12'hF68, 12'hA4F, 12'hC75
  };

  golay_rsp_t expected_rsps [$];
  golay_rsp_t oldest_rsp;
  int         fails;

  function automatic logic [11:0] row_xor(input logic use_inverse, input logic [11:0] v);
    logic [11:0] acc;
    acc = '0;
    for (int k = 0; k < 12; k++) begin
      if (v[k]) begin
        acc ^= use_inverse ? INVERSE_ROWS[k] : PARITY_ROWS[k];
      end
    end
    return acc;
  endfunction

  function automatic golay_rsp_t predict_rsp(input golay_req_t rq);
    golay_rsp_t  p;
    logic [11:0] data;
    logic [11:0] syn;
    logic [11:0] isyn;
    logic [11:0] rest;
    logic [23:0] mask;
    logic        found;
    p     = '0;
    data  = rq.word_in[11:0];
    mask  = '0;
    found = 1'b0;
    if (rq.opcode == OP_ENCODE) begin
      p.result_word = {row_xor(1'b0, data), data};
      return p;
    end
    syn = rq.word_in[23:12] ^ row_xor(1'b0, data);
    if ($countones(syn) <= 3) begin
      mask  = {syn, 12'h000};
      found = 1'b1;
    end
    for (int k = 0; k < 12 && !found; k++) begin
      rest = syn ^ PARITY_ROWS[k];
      if ($countones(rest) <= 2) begin
        mask  = {rest, 12'h000} | (24'h1 << k);
        found = 1'b1;
      end
    end
    isyn = row_xor(1'b1, syn);
    if (!found && $countones(isyn) <= 3) begin
      mask  = {12'h000, isyn};
      found = 1'b1;
    end
    for (int k = 0; k < 12 && !found; k++) begin
      rest = isyn ^ INVERSE_ROWS[k];
      if ($countones(rest) <= 2) begin
        mask  = {12'h000, rest} | (24'h1 << (k + 12));
        found = 1'b1;
      end
    end
    if (found) begin
      p.result_word = {12'h000, data ^ mask[11:0]};
      p.error_mask  = mask;
    end else begin
      p.uncorrectable = 1'b1;
    end
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_rsps.delete();
      fails      = 0;
      pending_o  <= 0;
      fail_cnt_o <= 0;
    end else begin
      if (start_i && !busy_i) begin
        expected_rsps.push_back(predict_rsp(req_i));
      end
      if (done_i) begin
        if (expected_rsps.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual %h", $time, rsp_i);
        end else begin
          oldest_rsp = expected_rsps.pop_front();
          if (rsp_i.result_word !== oldest_rsp.result_word) begin
            fails++;
            $display("%0t: result_word mismatch, expected %h, actual %h",
                     $time, oldest_rsp.result_word, rsp_i.result_word);
          end
          if (rsp_i.error_mask !== oldest_rsp.error_mask) begin
            fails++;
            $display("%0t: error_mask mismatch, expected %h, actual %h",
                     $time, oldest_rsp.error_mask, rsp_i.error_mask);
          end
          if (rsp_i.uncorrectable !== oldest_rsp.uncorrectable) begin
            fails++;
            $display("%0t: uncorrectable mismatch, expected %b, actual %b",
                     $time, oldest_rsp.uncorrectable, rsp_i.uncorrectable);
          end
        end
      end
      pending_o  <= expected_rsps.size();
      fail_cnt_o <= fails;
    end
  end

endmodule

// ----- tb/tb_golay_24_12_codec.sv -----
// Testbench top for the Golay (24,12) codec: reset, request stimulus and verdict.
module tb_golay_24_12_codec
  import golay_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomReqs = 650;
  localparam int CycleLimit = 200000;

  logic       clk;
  logic       rst_n;
  logic       start;
  golay_req_t req;
  logic       busy;
  logic       done;
  golay_rsp_t rsp;
  int         pending;
  int         fail_cnt;

  golay_24_12_codec DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .start  (start),
    .req_i  (req),
    .busy   (busy),
    .done_o (done),
    .rsp_o  (rsp)
  );

  golay_codec_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_i     (busy),
    .req_i      (req),
    .done_i     (done),
    .rsp_i      (rsp),
    .pending_o  (pending),
    .fail_cnt_o (fail_cnt)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [23:0] codeword(input logic [11:0] d);
    return {enc_mul(d), d};
  endfunction

  function automatic logic [23:0] rand_flips(input int weight);
    logic [23:0] m;
    logic [4:0]  pos;
    m = '0;
    while ($countones(m) < weight) begin
      pos    = 5'($urandom_range(0, 23));
      m[pos] = 1'b1;
    end
    return m;
  endfunction

  task automatic send_req(input op_e op, input logic [23:0] w, input int gap);
    golay_req_t r;
    r.opcode  = op;
    r.word_in = w;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("golay_24_12_codec regression: fail");
    $finish;
  end

  initial begin
    int          sel;
    int          weight;
    int          gap;
    logic        burst;
    logic [23:0] w;
    rst_n <= 1'b0;
    start <= 1'b0;
    req   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(OP_ENCODE, 24'h000000, 0);
    send_req(OP_ENCODE, 24'h000FFF, 0);
    send_req(OP_ENCODE, 24'hFFFFFF, 1);
    send_req(OP_ENCODE, 24'hABC5A5, 0);
    send_req(OP_DECODE, codeword(12'h000), 2);
    send_req(OP_DECODE, codeword(12'hFFF), 0);
    send_req(OP_DECODE, codeword(12'h5A5) ^ 24'h001000, 0);
    send_req(OP_DECODE, codeword(12'h5A5) ^ 24'hE00000, 3);
    send_req(OP_DECODE, codeword(12'h3C3) ^ 24'h800800, 0);
    send_req(OP_DECODE, codeword(12'h3C3) ^ 24'h801001, 0);
    send_req(OP_DECODE, codeword(12'h0F0) ^ 24'h000001, 4);
    send_req(OP_DECODE, codeword(12'h0F0) ^ 24'h000801, 0);
    send_req(OP_DECODE, codeword(12'h0F0) ^ 24'h000821, 0);
    send_req(OP_DECODE, codeword(12'h9E1) ^ 24'h100088, 0);
    send_req(OP_DECODE, codeword(12'h9E1) ^ 24'h003003, 1);
    send_req(OP_DECODE, codeword(12'h777) ^ 24'h00000F, 0);
    send_req(OP_DECODE, codeword(12'h777) ^ 24'hF00000, 0);
    send_req(OP_DECODE, codeword(12'h124) ^ 24'h81C011, 0);
    send_req(OP_DECODE, 24'hFFFFFF, 2);
    send_req(OP_DECODE, 24'h000FFF, 0);
    send_req(OP_DECODE, 24'hFFF000, 0);
    send_req(OP_DECODE, 24'hA5A5A5, 0);
    drain();

    burst = 1'b0;
    for (int i = 0; i < RandomReqs; i++) begin
      if (i % 40 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
      end
      gap = burst ? 0 : $urandom_range(0, 4);
      sel = $urandom_range(0, 9);
      if (sel <= 2) begin
        w = 24'($urandom());
        send_req(OP_ENCODE, w, gap);
      end else if (sel <= 8) begin
        case ($urandom_range(0, 9))
          0:       weight = 0;
          1, 2:    weight = 1;
          3, 4:    weight = 2;
          5, 6:    weight = 3;
          7, 8:    weight = 4;
          default: weight = 5;
        endcase
        w = codeword(12'($urandom_range(0, 4095))) ^ rand_flips(weight);
        send_req(OP_DECODE, w, gap);
      end else begin
        w = 24'($urandom());
        send_req(OP_DECODE, w, gap);
      end
      if (i == RandomReqs / 2) begin
        drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("golay_24_12_codec regression: pass");
    end else begin
      $display("golay_24_12_codec regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/golay_pkg.sv
rtl/core/golay_24_12_codec.sv
tb/golay_codec_checker.sv
tb/tb_golay_24_12_codec.sv
